// File: src/pbs_pkg.sv
// Shared types and constants for the per-protocol packet and byte counters.
package pbs_pkg;

  localparam int NUM_SLOTS       = 259;
  localparam int MAX_FRAME_BYTES = 16383;
  localparam int SLOT_W          = 9;
  localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CNT_W           = 64;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;

  localparam logic [SLOT_W-1:0] ARP_SLOT   = SLOT_W'(256);
  localparam logic [SLOT_W-1:0] IPV6_SLOT  = SLOT_W'(257);
  localparam logic [SLOT_W-1:0] OTHER_SLOT = SLOT_W'(258);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NUM_SLOTS - 1);

  localparam logic [LEN_W-1:0] POS_ETYPE_HI = LEN_W'(12);
  localparam logic [LEN_W-1:0] POS_ETYPE_LO = LEN_W'(13);
  localparam logic [LEN_W-1:0] POS_IP_PROTO = LEN_W'(23);
  localparam logic [LEN_W-1:0] MIN_ETH_LEN  = LEN_W'(14);
  localparam logic [LEN_W-1:0] MIN_IPV4_LEN = LEN_W'(34);
  localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(MAX_FRAME_BYTES);

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  // Request from the parser to the counter pipeline.
  typedef struct packed {
    logic              valid;
    logic              is_frame;
    logic              counted;
    logic              out_of_range;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } req_t;

endpackage

// File: src/pbs_ifs.sv
// Input and output channel interfaces.
interface pbs_in_if import pbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [7:0]        frame_byte;
  logic              end_of_frame;
  logic [SLOT_W-1:0] read_slot;

  modport source (output valid, func, frame_byte, end_of_frame, read_slot, input ready);
  modport sink   (input valid, func, frame_byte, end_of_frame, read_slot, output ready);
endinterface

interface pbs_out_if import pbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_done;
  logic              counted;
  logic [SLOT_W-1:0] slot_used;
  logic [CNT_W-1:0]  packet_count;
  logic [CNT_W-1:0]  byte_count;

  modport source (output valid, frame_done, counted, slot_used, packet_count, byte_count,
                  input ready);
  modport sink   (input valid, frame_done, counted, slot_used, packet_count, byte_count,
                  output ready);
endinterface

// File: src/pbs_parser.sv
// Frame header tracking and slot classification.
module pbs_parser import pbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              func,
  input  logic [7:0]        frame_byte,
  input  logic              end_of_frame,
  input  logic [SLOT_W-1:0] read_slot,
  output req_t              req
);

  logic [LEN_W-1:0] byte_position;
  logic [15:0]      ether_type;
  logic [7:0]       ip_protocol;

  logic [LEN_W-1:0] len;
  logic [15:0]      etype_cur;
  logic [7:0]       proto_cur;
  logic             ok;
  logic [SLOT_W-1:0] slot;
  logic             is_read;

  assign is_read = (func == FUNC_READ);

  always_comb begin
    etype_cur = ether_type;
    proto_cur = ip_protocol;
    if (byte_position == POS_ETYPE_HI) begin
      etype_cur = {frame_byte, ether_type[7:0]};
    end else if (byte_position == POS_ETYPE_LO) begin
      etype_cur = {ether_type[15:8], frame_byte};
    end else if (byte_position == POS_IP_PROTO) begin
      proto_cur = frame_byte;
    end
    len = (byte_position < LEN_MAX) ? byte_position + LEN_W'(1) : LEN_MAX;

    ok   = 1'b0;
    slot = '0;
    if (len >= MIN_ETH_LEN) begin
      if (etype_cur == ETYPE_ARP) begin
        ok   = 1'b1;
        slot = ARP_SLOT;
      end else if (etype_cur == ETYPE_IPV6) begin
        ok   = 1'b1;
        slot = IPV6_SLOT;
      end else if (etype_cur != ETYPE_IPV4) begin
        ok   = 1'b1;
        slot = OTHER_SLOT;
      end else if (len >= MIN_IPV4_LEN) begin
        ok   = 1'b1;
        slot = {1'b0, proto_cur};
      end
    end
  end

  always_comb begin
    req              = '0;
    req.valid        = accept && (is_read || end_of_frame);
    req.is_frame     = !is_read;
    req.len          = len;
    if (is_read) begin
      req.out_of_range = (read_slot > SLOT_LAST);
      req.slot         = (read_slot > SLOT_LAST) ? '0 : read_slot;
    end else begin
      req.counted = ok;
      req.slot    = ok ? slot : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ether_type    <= '0;
      ip_protocol   <= '0;
    end else if (accept && !is_read) begin
      if (end_of_frame) begin
        byte_position <= '0;
        ether_type    <= '0;
        ip_protocol   <= '0;
      end else begin
        byte_position <= len;
        ether_type    <= etype_cur;
        ip_protocol   <= proto_cur;
      end
    end
  end

endmodule

// File: src/pbs_update.sv
// Counter memory with read-modify-write pipeline, clear sweep and result register.
module pbs_update import pbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  output logic       take_ok,
  pbs_out_if.source  out_ch
);

  logic [2*CNT_W-1:0] mem [NUM_SLOTS];
  logic [2*CNT_W-1:0] rd_data;

  logic               clearing;
  logic [SLOT_W-1:0]  clr_addr;

  logic               s1_valid;
  req_t               s1;

  logic               fwd_valid;
  logic [SLOT_W-1:0]  fwd_addr;
  logic [2*CNT_W-1:0] fwd_data;

  logic               advance;
  logic               we;
  logic [CNT_W-1:0]   cur_pkt;
  logic [CNT_W-1:0]   cur_oct;
  logic [CNT_W-1:0]   new_pkt;
  logic [CNT_W-1:0]   new_oct;

  assign advance = !out_ch.valid || out_ch.ready;
  assign take_ok = advance && !clearing;

  // Bypass the write that landed after this entry was read.
  always_comb begin
    if (fwd_valid && fwd_addr == s1.slot) begin
      {cur_pkt, cur_oct} = fwd_data;
    end else begin
      {cur_pkt, cur_oct} = rd_data;
    end
    new_pkt = cur_pkt + CNT_W'(1);
    new_oct = cur_oct + CNT_W'(s1.len);
  end

  assign we = s1_valid && advance && s1.is_frame && s1.counted;

  always_ff @(posedge clk) begin
    if (req.valid) begin
      rd_data <= mem[req.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[s1.slot] <= {new_pkt, new_oct};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + SLOT_W'(1);
      if (clr_addr == SLOT_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= req.valid;
      end
      if (we) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= req;
    end
    if (we) begin
      fwd_addr <= s1.slot;
      fwd_data <= {new_pkt, new_oct};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.frame_done <= s1.is_frame;
      out_ch.counted    <= s1.is_frame && s1.counted;
      out_ch.slot_used  <= (s1.is_frame && s1.counted) ? s1.slot : '0;
      if (!s1.is_frame && !s1.out_of_range) begin
        out_ch.packet_count <= cur_pkt;
        out_ch.byte_count   <= cur_oct;
      end else begin
        out_ch.packet_count <= '0;
        out_ch.byte_count   <= '0;
      end
    end
  end

  a_no_pipe_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !req.valid)
    else $error("request in flight during clear sweep");

  a_write_only_counted: assert property (@(posedge clk) disable iff (rst)
    we |-> s1.is_frame && s1.counted && !clearing)
    else $error("counter write without a counted frame");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    we |=> fwd_valid && fwd_addr == $past(s1.slot))
    else $error("bypass register missed a write");

  a_read_result_fields: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.frame_done |-> !out_ch.counted && out_ch.slot_used == '0)
    else $error("read result carries frame fields");

  a_frame_result_counts: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.frame_done |-> out_ch.packet_count == '0
      && out_ch.byte_count == '0)
    else $error("frame result carries counter values");

endmodule

// File: src/protocol_packet_byte_statistics_core.sv
// A transfer is registered in stage s1, then in the result register, from which it can leave.
// Throughput: one input transfer per cycle when ready; bytes and reads may interleave freely.
// Rate set by the counter memory: one read and one write port give one read-modify-write
// per cycle, with a one-entry bypass covering back-to-back updates of the same slot.
// Reset: synchronous; a clear sweep then zeroes all 259 slots,
// during which input ready stays low.
module protocol_packet_byte_statistics_core import pbs_pkg::*; (
  input logic      clk,
  input logic      rst,
  pbs_in_if.sink   in_ch,
  pbs_out_if.source out_ch
);

  logic accept;
  logic take_ok;
  req_t req;

  // Input transfer; ready drops only during the clear sweep or when the
  // result register is full and not being drained.
  assign in_ch.ready = take_ok;
  assign accept      = in_ch.valid && take_ok;

  // Header capture, length count and slot choice per frame byte.
  pbs_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .func         (in_ch.func),
    .frame_byte   (in_ch.frame_byte),
    .end_of_frame (in_ch.end_of_frame),
    .read_slot    (in_ch.read_slot),
    .req          (req)
  );

  // Counter memory: read at transfer, add and write back from stage s1 when it advances.
  pbs_update u_update (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule
